FILE: rtl/core/postfix_stack_evaluator_defines.svh
// Assertion macros used by the postfix stack evaluator top level.
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pse_pkg.sv
// Shared constants and types of the postfix stack evaluator.
package pse_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned DEPTH_W         = 5;

  localparam logic [1:0] KIND_VAR   = 2'd0;
  localparam logic [1:0] KIND_OP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/core/pse_stack_mem.sv
// Synchronous operand stack memory with one write and one registered read port.
module pse_stack_mem
  import pse_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pse_divider.sv
// Radix-2 signed divider, truncating, one quotient bit per cycle.
module pse_divider
  import pse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] quo_step;

  always_comb begin
    rem_shift = {rem_q, quo_q[DATA_W-1]};
    diff      = rem_shift - {1'b0, den_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    den_d     = den_q;
    neg_d     = neg_q;
    res_d     = res_q;
    quo_step  = {quo_q[DATA_W-2:0], !diff[DATA_W]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[DATA_W-1] ? -req_i.dividend : req_i.dividend;
      den_d  = req_i.divisor[DATA_W-1] ? -req_i.divisor : req_i.divisor;
      neg_d  = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
    end else if (busy_q) begin
      rem_d = diff[DATA_W] ? rem_shift[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_d = quo_step;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -quo_step : quo_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o     = done_q;
  assign quotient_o = res_q;

endmodule

FILE: rtl/core/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator.
//
// Tokens come in on the s_axis channel: tuser carries the token kind and tdata the
// variable index or operator. Each accepted token gives exactly one result on the
// m_axis channel: the top of stack, the depth and an error code.
// For variable pushes, clear tokens, ignored tokens and rejected operators the result
// is valid on the cycle after acceptance.
// Add, subtract and multiply go through the read of the next-to-top entry from the
// stack memory (S_READ) and a write-back (S_WB) before the result is loaded.
// Divide goes through the stack read that also starts the radix-2 divider, the 32
// quotient bits at one per cycle, the hand-over of the quotient (S_DIV) and the
// write-back. Division by zero skips the divider and goes straight to write-back.
// One token is in work at a time; the next is taken once the previous has finished.
// The result sits in an output register; a new token is taken only when that register
// is empty or its result leaves in the same cycle, so while the receiver stalls a full
// output register, s_axis_tready stays low.
// Reset empties the stack, clears the sticky underflow and the variable registers.
// The stack memory is not cleared; only entries below the depth are ever read.
// Write the variable registers over APB only while no token is in work (not enforced).
`include "postfix_stack_evaluator_defines.svh"

module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [1:0] symbol
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] top_value, [36:32] depth, [38:37] error_code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               uflow_q, uflow_d;
  logic [DATA_W-1:0]  top_q, top_d;
  logic [1:0]         op_q, op_d;
  logic [DATA_W-1:0]  res_q, res_d;
  logic [DATA_W-1:0]  var_q [4];

  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  out_top_q, out_top_d;
  logic [DEPTH_W-1:0] out_depth_q, out_depth_d;
  logic [1:0]         out_err_q, out_err_d;
  logic               out_load;

  logic               in_acc;
  logic [1:0]         kind;
  logic [1:0]         symbol;
  logic [DATA_W-1:0]  cur_top;
  logic [CW-1:0]      next_cnt;
  logic [AW-1:0]      next_idx;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic [DATA_W-1:0]  mem_rdata;

  div_req_t           div_req;
  logic               div_done;
  logic [DATA_W-1:0]  div_quot;

  assign kind     = s_axis_tuser;
  assign symbol   = s_axis_tdata[1:0];
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cur_top  = (count_q != '0) ? top_q : '0;
  assign next_cnt = count_q - CW'(2);
  assign next_idx = next_cnt[AW-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        var_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      var_q[paddr[3:2]] <= pwdata;
    end
  end

  assign prdata = var_q[paddr[3:2]];
  assign pready = 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    uflow_d     = uflow_q;
    top_d       = top_q;
    op_d        = op_q;
    res_d       = res_q;
    out_load    = 1'b0;
    out_top_d   = cur_top;
    out_depth_d = DEPTH_W'(count_q);
    out_err_d   = uflow_q ? ERR_UNDERFLOW : ERR_NONE;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = var_q[symbol];
    div_req     = '{start: 1'b0, dividend: mem_rdata, divisor: top_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          if (kind == KIND_CLEAR) begin
            count_d     = '0;
            uflow_d     = 1'b0;
            out_top_d   = '0;
            out_depth_d = '0;
            out_err_d   = ERR_NONE;
          end else if (!uflow_q && kind == KIND_VAR) begin
            if (count_q < CW'(STACK_DEPTH)) begin
              mem_we      = 1'b1;
              top_d       = var_q[symbol];
              count_d     = count_q + CW'(1);
              out_top_d   = var_q[symbol];
              out_depth_d = DEPTH_W'(count_q + CW'(1));
            end else begin
              out_err_d = ERR_OVERFLOW;
            end
          end else if (!uflow_q && kind == KIND_OP) begin
            if (count_q < CW'(2)) begin
              uflow_d   = 1'b1;
              out_err_d = ERR_UNDERFLOW;
            end else begin
              out_load = 1'b0;
              mem_re   = 1'b1;
              op_d     = symbol;
              state_d  = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_WB;
        case (op_q)
          OP_ADD: res_d = top_q + mem_rdata;
          OP_SUB: res_d = top_q - mem_rdata;
          OP_MUL: res_d = top_q * mem_rdata;
          default: begin
            if (top_q == '0) begin
              res_d = '0;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_quot;
          state_d = S_WB;
        end
      end
      S_WB: begin
        mem_we      = 1'b1;
        mem_waddr   = next_idx;
        mem_wdata   = res_q;
        top_d       = res_q;
        count_d     = count_q - CW'(1);
        out_load    = 1'b1;
        out_top_d   = res_q;
        out_depth_d = DEPTH_W'(count_q - CW'(1));
        out_err_d   = ERR_NONE;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      uflow_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      uflow_q     <= uflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    op_q  <= op_d;
    res_q <= res_d;
    if (out_load) begin
      out_top_q   <= out_top_d;
      out_depth_q <= out_depth_d;
      out_err_q   <= out_err_d;
    end
  end

  pse_stack_mem #(
    .DEPTH(STACK_DEPTH)
  ) u_stack_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(next_idx),
    .rdata_o(mem_rdata)
  );

  pse_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_err_q, out_depth_q, out_top_q};

  `PSE_ASSERT_IMPL(a_ready_only_idle, clk_i, rst_ni, s_axis_tready, state_q == S_IDLE, "token request taken while busy")
  `PSE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count above depth")
  `PSE_ASSERT_NEXT(a_op_reads, clk_i, rst_ni, in_acc && !uflow_q && kind == KIND_OP && count_q >= CW'(2), state_q == S_READ, "operator did not read the stack")
  `PSE_ASSERT_IMPL(a_sticky_err, clk_i, rst_ni, m_axis_tvalid && uflow_q, m_axis_tdata[38:37] == ERR_UNDERFLOW, "sticky underflow not reported")

endmodule
